/* src/nbp_pkg.sv */
// ============================================================================
// nbp_pkg: shared constants, types and tables of the naive Bayes posterior
// Widths, pipeline depths, register indexes and the exponent table.
// ============================================================================
package nbp_pkg;

    localparam int PROB_BITS           = 16;
    localparam int VALUE_FRACTION_BITS = 4;
    localparam int EXP_TABLE_DEPTH     = 256;
    localparam int TAYLOR_TERMS        = 12;

    localparam int CAT_W     = 2;
    localparam int IN_VAL_W  = 11;
    localparam int VAL_W     = 16;
    localparam int D2_W      = 2 * VAL_W;
    localparam int EXP_Q_BITS = 12;
    localparam int EXP_SHIFT = 8 - (VALUE_FRACTION_BITS + 1);
    localparam int EXP_N_W   = D2_W + EXP_SHIFT;
    localparam int EREM_W    = VAL_W + EXP_Q_BITS;
    localparam int EXP_IDX_W = $clog2(EXP_TABLE_DEPTH);
    localparam int E_W       = 33;

    localparam int ISQ_DIV_STEPS = 32 + VALUE_FRACTION_BITS + 1;
    localparam int SQRT_STEPS    = (ISQ_DIV_STEPS + 1) / 2;
    localparam int ISQ_W         = SQRT_STEPS;
    localparam int SQ_W          = 2 * SQRT_STEPS;
    localparam int SREM_W        = ISQ_W + 2;
    localparam int ISQ_LAT       = ISQ_DIV_STEPS + SQRT_STEPS;

    localparam int E_STAGE  = EXP_Q_BITS + 3;
    localparam int E_DLY    = ISQ_LAT - (E_STAGE + 1);
    localparam int A_DLY    = ISQ_LAT - 2;
    localparam int NUM_W    = PROB_BITS + ISQ_W;
    localparam int DEN_W    = NUM_W + 1;
    localparam int POST_STEPS = PROB_BITS;
    localparam int TOTAL_LAT  = ISQ_LAT + 2 + POST_STEPS + 1;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_ADDR_W-1:0] REG_CAT_NEG   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CAT_POS   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BIN_LH    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PRIORS    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MEANS     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_VARIANCES = 3'd5;

    localparam logic [CAT_W-1:0] CAT_ONE   = 2'd1;
    localparam logic [CAT_W-1:0] CAT_TWO   = 2'd2;
    localparam logic [CAT_W-1:0] CAT_THREE = 2'd3;

    typedef logic [E_W-1:0] exp_rom_t [EXP_TABLE_DEPTH];

    // exp(-16*i/depth) in Q1.32, built by repeated multiplication with a
    // truncated Taylor approximation of one step.
    function automatic exp_rom_t build_exp_rom();
        logic [63:0] step_h;
        logic [63:0] term;
        logic [63:0] s;
        logic [63:0] acc;
        exp_rom_t    rom;
        step_h = (64'd1 << 36) / EXP_TABLE_DEPTH;
        term   = 64'd1 << 32;
        s      = term;
        for (int k = 1; k <= TAYLOR_TERMS; k++) begin
            term = ((term * step_h) >> 32) / 64'(k);
            if ((k % 2) == 1) begin
                s = s - term;
            end
            else begin
                s = s + term;
            end
        end
        acc    = 64'd1 << 32;
        rom[0] = acc[E_W-1:0];
        for (int i = 1; i < EXP_TABLE_DEPTH; i++) begin
            acc    = (acc * s) >> 32;
            rom[i] = acc[E_W-1:0];
        end
        return rom;
    endfunction

    localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

/* src/nbp_isq.sv */
// ============================================================================
// nbp_isq: pipelined inverse square root of the variance
// One restoring divide bit per stage, then one root bit per stage.
// ============================================================================
module nbp_isq import nbp_pkg::*; (
    input  logic             clk,
    input  logic [VAL_W-1:0] variance,
    output logic [ISQ_W-1:0] isq
);

    logic [VAL_W-1:0]         drem_reg  [ISQ_DIV_STEPS];
    logic [ISQ_DIV_STEPS-1:0] dq_reg    [ISQ_DIV_STEPS];
    logic [VAL_W-1:0]         drem_next [ISQ_DIV_STEPS];
    logic [ISQ_DIV_STEPS-1:0] dq_next   [ISQ_DIV_STEPS];

    logic [SREM_W-1:0] srem_reg   [SQRT_STEPS];
    logic [ISQ_W-1:0]  sroot_reg  [SQRT_STEPS];
    logic [SQ_W-1:0]   sd_reg     [SQRT_STEPS];
    logic [SREM_W-1:0] srem_next  [SQRT_STEPS];
    logic [ISQ_W-1:0]  sroot_next [SQRT_STEPS];
    logic [SQ_W-1:0]   sd_next    [SQRT_STEPS];

    // The dividend is a single one at its top bit, fed in the first step.
    always_comb begin
        logic [VAL_W-1:0]         prem;
        logic [ISQ_DIV_STEPS-1:0] pq;
        logic [VAL_W:0]           sh;
        for (int i = 0; i < ISQ_DIV_STEPS; i++) begin
            prem = (i == 0) ? '0 : drem_reg[(i == 0) ? 0 : i - 1];
            pq   = (i == 0) ? '0 : dq_reg[(i == 0) ? 0 : i - 1];
            sh   = {prem, (i == 0) ? 1'b1 : 1'b0};
            if (sh >= {1'b0, variance}) begin
                drem_next[i] = VAL_W'(sh - {1'b0, variance});
                dq_next[i]   = pq | (ISQ_DIV_STEPS'(1) << (ISQ_DIV_STEPS - 1 - i));
            end
            else begin
                drem_next[i] = sh[VAL_W-1:0];
                dq_next[i]   = pq;
            end
        end
    end

    always_comb begin
        logic [SREM_W-1:0] prem;
        logic [ISQ_W-1:0]  proot;
        logic [SQ_W-1:0]   pd;
        logic [SREM_W+1:0] sh;
        logic [SREM_W+1:0] trial;
        for (int i = 0; i < SQRT_STEPS; i++) begin
            prem  = (i == 0) ? '0 : srem_reg[(i == 0) ? 0 : i - 1];
            proot = (i == 0) ? '0 : sroot_reg[(i == 0) ? 0 : i - 1];
            pd    = (i == 0) ? SQ_W'(dq_reg[ISQ_DIV_STEPS-1]) : sd_reg[(i == 0) ? 0 : i - 1];
            sh    = {prem, pd[2*(SQRT_STEPS-1-i) +: 2]};
            trial = (SREM_W + 2)'({proot, 2'b01});
            sd_next[i] = pd;
            if (sh >= trial) begin
                srem_next[i]  = SREM_W'(sh - trial);
                sroot_next[i] = {proot[ISQ_W-2:0], 1'b1};
            end
            else begin
                srem_next[i]  = sh[SREM_W-1:0];
                sroot_next[i] = {proot[ISQ_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk) begin
        for (int i = 0; i < ISQ_DIV_STEPS; i++) begin
            drem_reg[i] <= drem_next[i];
            dq_reg[i]   <= dq_next[i];
        end
        for (int i = 0; i < SQRT_STEPS; i++) begin
            srem_reg[i]  <= srem_next[i];
            sroot_reg[i] <= sroot_next[i];
            sd_reg[i]    <= sd_next[i];
        end
    end

    assign isq = sroot_reg[SQRT_STEPS-1];

endmodule

/* src/nbp_class.sv */
// ============================================================================
// nbp_class: per-class likelihood product pipeline
// Table lookups, exponent argument division, exponent table and Gaussian.
// ============================================================================
module nbp_class import nbp_pkg::*; (
    input  logic                   clk,
    input  logic [CAT_W-1:0]       cat,
    input  logic                   bin,
    input  logic [IN_VAL_W-1:0]    value,
    input  logic [3*PROB_BITS-1:0] cat_lh,
    input  logic [2*PROB_BITS-1:0] bin_lh,
    input  logic [PROB_BITS-1:0]   prior,
    input  logic [VAL_W-1:0]       mean,
    input  logic [VAL_W-1:0]       variance,
    output logic [NUM_W-1:0]       num
);

    logic [PROB_BITS-1:0] c_reg, c_next, b_reg, b_next;
    logic [VAL_W-1:0]     d_reg, d_next;
    logic [D2_W-1:0]      d2_reg, d2_next;
    logic [PROB_BITS-1:0] ab_reg, ab_next, a_reg, a_next;
    logic [EREM_W-1:0]    rem_reg, rem_next;
    logic                 ovf_reg, ovf_next;
    logic [2*PROB_BITS-1:0] prod_cb, prod_ap;
    logic [VAL_W-1:0]     value_ext;
    logic [EXP_N_W-1:0]   n_ext;
    logic [EREM_W-1:0]    lim;

    logic [EREM_W-1:0]     erem_reg  [EXP_Q_BITS];
    logic [EXP_Q_BITS-1:0] eq_reg    [EXP_Q_BITS];
    logic                  eovf_reg  [EXP_Q_BITS];
    logic [EREM_W-1:0]     erem_next [EXP_Q_BITS];
    logic [EXP_Q_BITS-1:0] eq_next   [EXP_Q_BITS];
    logic                  eovf_next [EXP_Q_BITS];

    logic [E_W-1:0]       e_reg, e_next;
    logic [E_W-1:0]       edly_reg [E_DLY];
    logic [PROB_BITS-1:0] adly_reg [A_DLY];
    logic [ISQ_W-1:0]     isq;
    logic [ISQ_W+E_W-1:0] prod_ge;
    logic [ISQ_W-1:0]     g_reg, g_next;
    logic [NUM_W-1:0]     num_reg, num_next;

    nbp_isq u_isq (
        .clk      (clk),
        .variance (variance),
        .isq      (isq)
    );

    // Category values with no table entry give a likelihood of zero.
    always_comb begin
        case (cat)
            CAT_ONE:   c_next = cat_lh[0 +: PROB_BITS];
            CAT_TWO:   c_next = cat_lh[PROB_BITS +: PROB_BITS];
            CAT_THREE: c_next = cat_lh[2*PROB_BITS +: PROB_BITS];
            default:   c_next = '0;
        endcase
        b_next    = bin ? bin_lh[PROB_BITS +: PROB_BITS] : bin_lh[0 +: PROB_BITS];
        value_ext = VAL_W'(value);
        d_next    = (value_ext > mean) ? value_ext - mean : mean - value_ext;
    end

    assign d2_next = d_reg * d_reg;
    assign prod_cb = c_reg * b_reg;
    assign ab_next = prod_cb[2*PROB_BITS-1:PROB_BITS];

    assign prod_ap  = ab_reg * prior;
    assign a_next   = prod_ap[2*PROB_BITS-1:PROB_BITS];
    assign n_ext    = {d2_reg, {EXP_SHIFT{1'b0}}};
    assign lim      = {variance, {EXP_Q_BITS{1'b0}}};
    assign ovf_next = n_ext >= EXP_N_W'(lim);
    assign rem_next = n_ext[EREM_W-1:0];

    always_comb begin
        logic [EREM_W-1:0]     prem;
        logic [EXP_Q_BITS-1:0] pq;
        logic                  povf;
        logic [EREM_W-1:0]     trial;
        for (int k = 0; k < EXP_Q_BITS; k++) begin
            prem  = (k == 0) ? rem_reg : erem_reg[(k == 0) ? 0 : k - 1];
            pq    = (k == 0) ? '0 : eq_reg[(k == 0) ? 0 : k - 1];
            povf  = (k == 0) ? ovf_reg : eovf_reg[(k == 0) ? 0 : k - 1];
            trial = lim >> (k + 1);
            eovf_next[k] = povf;
            if (prem >= trial) begin
                erem_next[k] = prem - trial;
                eq_next[k]   = pq | (EXP_Q_BITS'(1) << (EXP_Q_BITS - 1 - k));
            end
            else begin
                erem_next[k] = prem;
                eq_next[k]   = pq;
            end
        end
    end

    assign e_next = eovf_reg[EXP_Q_BITS-1] ? '0 :
                    EXP_ROM[eq_reg[EXP_Q_BITS-1][EXP_Q_BITS-1 -: EXP_IDX_W]];

    assign prod_ge  = isq * edly_reg[E_DLY-1];
    assign g_next   = (variance == '0) ? '0 : prod_ge[32 +: ISQ_W];
    assign num_next = adly_reg[A_DLY-1] * g_reg;

    always_ff @(posedge clk) begin
        c_reg   <= c_next;
        b_reg   <= b_next;
        d_reg   <= d_next;
        d2_reg  <= d2_next;
        ab_reg  <= ab_next;
        a_reg   <= a_next;
        rem_reg <= rem_next;
        ovf_reg <= ovf_next;
        for (int k = 0; k < EXP_Q_BITS; k++) begin
            erem_reg[k] <= erem_next[k];
            eq_reg[k]   <= eq_next[k];
            eovf_reg[k] <= eovf_next[k];
        end
        e_reg       <= e_next;
        edly_reg[0] <= e_reg;
        for (int k = 1; k < E_DLY; k++) begin
            edly_reg[k] <= edly_reg[k-1];
        end
        adly_reg[0] <= a_reg;
        for (int k = 1; k < A_DLY; k++) begin
            adly_reg[k] <= adly_reg[k-1];
        end
        g_reg   <= g_next;
        num_reg <= num_next;
    end

    assign num = num_reg;

endmodule

/* src/nbp_post.sv */
// ============================================================================
// nbp_post: normalization into two posteriors
// Sums the class products and divides each by the sum, one bit per stage.
// ============================================================================
module nbp_post import nbp_pkg::*; (
    input  logic                 clk,
    input  logic [NUM_W-1:0]     num_neg,
    input  logic [NUM_W-1:0]     num_pos,
    output logic [PROB_BITS-1:0] prob_neg,
    output logic [PROB_BITS-1:0] prob_pos,
    output logic                 pred_pos,
    output logic                 none
);

    logic [DEN_W-1:0] n_reg [2];
    logic [DEN_W-1:0] den_reg;
    logic             none_reg;

    logic [DEN_W-1:0]     rem_reg  [2][POST_STEPS];
    logic [PROB_BITS-1:0] q_reg    [2][POST_STEPS];
    logic                 sat_reg  [2][POST_STEPS];
    logic [DEN_W-1:0]     rem_next [2][POST_STEPS];
    logic [PROB_BITS-1:0] q_next   [2][POST_STEPS];
    logic                 sat_next [2][POST_STEPS];
    logic [DEN_W-1:0]     dden_reg  [POST_STEPS];
    logic                 dnone_reg [POST_STEPS];

    logic [PROB_BITS-1:0] pn_reg, pn_next, pp_reg, pp_next;
    logic                 none_out_reg;

    // A product equal to the sum would give one, which saturates.
    always_comb begin
        logic [DEN_W-1:0]     prem;
        logic [PROB_BITS-1:0] pq;
        logic                 psat;
        logic [DEN_W-1:0]     pden;
        logic [DEN_W:0]       sh;
        for (int c = 0; c < 2; c++) begin
            for (int j = 0; j < POST_STEPS; j++) begin
                prem = (j == 0) ? n_reg[c] : rem_reg[c][(j == 0) ? 0 : j - 1];
                pq   = (j == 0) ? '0 : q_reg[c][(j == 0) ? 0 : j - 1];
                psat = (j == 0) ? (n_reg[c] >= den_reg) : sat_reg[c][(j == 0) ? 0 : j - 1];
                pden = (j == 0) ? den_reg : dden_reg[(j == 0) ? 0 : j - 1];
                sh   = {prem, 1'b0};
                sat_next[c][j] = psat;
                if (sh >= {1'b0, pden}) begin
                    rem_next[c][j] = DEN_W'(sh - {1'b0, pden});
                    q_next[c][j]   = pq | (PROB_BITS'(1) << (PROB_BITS - 1 - j));
                end
                else begin
                    rem_next[c][j] = sh[DEN_W-1:0];
                    q_next[c][j]   = pq;
                end
            end
        end
    end

    assign pn_next = dnone_reg[POST_STEPS-1] ? '0 :
                     sat_reg[0][POST_STEPS-1] ? '1 : q_reg[0][POST_STEPS-1];
    assign pp_next = dnone_reg[POST_STEPS-1] ? '0 :
                     sat_reg[1][POST_STEPS-1] ? '1 : q_reg[1][POST_STEPS-1];

    always_ff @(posedge clk) begin
        n_reg[0] <= DEN_W'(num_neg);
        n_reg[1] <= DEN_W'(num_pos);
        den_reg  <= DEN_W'(num_neg) + DEN_W'(num_pos);
        none_reg <= (num_neg == '0) && (num_pos == '0);
        for (int c = 0; c < 2; c++) begin
            for (int j = 0; j < POST_STEPS; j++) begin
                rem_reg[c][j] <= rem_next[c][j];
                q_reg[c][j]   <= q_next[c][j];
                sat_reg[c][j] <= sat_next[c][j];
            end
        end
        dden_reg[0]  <= den_reg;
        dnone_reg[0] <= none_reg;
        for (int j = 1; j < POST_STEPS; j++) begin
            dden_reg[j]  <= dden_reg[j-1];
            dnone_reg[j] <= dnone_reg[j-1];
        end
        pn_reg       <= pn_next;
        pp_reg       <= pp_next;
        none_out_reg <= dnone_reg[POST_STEPS-1];
    end

    assign prob_neg = pn_reg;
    assign prob_pos = pp_reg;
    assign pred_pos = pp_reg[PROB_BITS-1];
    assign none     = none_out_reg;

endmodule

/* src/naive_bayes_two_class_posterior.sv */
// ============================================================================
// naive_bayes_two_class_posterior: two-class Gaussian naive Bayes classifier
// Fixed-point posteriors and a prediction for one record per clock.
// ============================================================================
// The block never pushes back: busy is always low and a record is taken in
// every cycle that start is high. Each record produces exactly one result
// beat, shown for one cycle with done high after the record has passed the
// whole pipeline; results leave in the order records came in and the
// receiver must take each beat in the cycle it appears. The depth is set by
// the inverse square root of the variance, a 37-stage restoring divider
// followed by a 19-stage square root, plus 16 stages of the final posterior
// divide. Configuration registers are written through cfg_we, cfg_addr and
// cfg_wdata; the user must do so only while no record is in flight, as the
// block does not enforce it. Indexes beyond the last register are ignored.
module naive_bayes_two_class_posterior import nbp_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    output logic                  done,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [CAT_W-1:0]      category_value,
    input  logic                  binary_value,
    input  logic [IN_VAL_W-1:0]   numeric_value,
    output logic [PROB_BITS-1:0]  prob_negative,
    output logic [PROB_BITS-1:0]  prob_positive,
    output logic                  predicted_positive,
    output logic                  no_evidence
);

    logic [3*PROB_BITS-1:0] cat_neg_reg;
    logic [3*PROB_BITS-1:0] cat_pos_reg;
    logic [4*PROB_BITS-1:0] bin_lh_reg;
    logic [2*PROB_BITS-1:0] priors_reg;
    logic [2*VAL_W-1:0]     means_reg;
    logic [2*VAL_W-1:0]     vars_reg;

    logic [TOTAL_LAT:0] vld_reg;
    logic [NUM_W-1:0]   num_neg;
    logic [NUM_W-1:0]   num_pos;

    // The pipeline always has room, so there is no back pressure.
    assign busy = 1'b0;

    // Configuration registers. The data path reads them at every stage; the user
    // must change them only when no record is in flight, which is not enforced.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cat_neg_reg <= '0;
            cat_pos_reg <= '0;
            bin_lh_reg  <= '0;
            priors_reg  <= '0;
            means_reg   <= '0;
            vars_reg    <= '0;
        end
        else if (cfg_we) begin
            case (cfg_addr)
                REG_CAT_NEG:   cat_neg_reg <= cfg_wdata[3*PROB_BITS-1:0];
                REG_CAT_POS:   cat_pos_reg <= cfg_wdata[3*PROB_BITS-1:0];
                REG_BIN_LH:    bin_lh_reg  <= cfg_wdata[4*PROB_BITS-1:0];
                REG_PRIORS:    priors_reg  <= cfg_wdata[2*PROB_BITS-1:0];
                REG_MEANS:     means_reg   <= cfg_wdata[2*VAL_W-1:0];
                REG_VARIANCES: vars_reg    <= cfg_wdata[2*VAL_W-1:0];
                default:       ;
            endcase
        end
    end

    // One valid bit per pipeline stage; the last one is the result strobe.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else begin
            vld_reg <= {vld_reg[TOTAL_LAT-1:0], start & ~busy};
        end
    end

    assign done = vld_reg[TOTAL_LAT];

    // Negative class: table entries for binary value and class index zero.
    nbp_class u_class_neg (
        .clk      (clk),
        .cat      (category_value),
        .bin      (binary_value),
        .value    (numeric_value),
        .cat_lh   (cat_neg_reg),
        .bin_lh   (bin_lh_reg[0 +: 2*PROB_BITS]),
        .prior    (priors_reg[0 +: PROB_BITS]),
        .mean     (means_reg[0 +: VAL_W]),
        .variance (vars_reg[0 +: VAL_W]),
        .num      (num_neg)
    );

    // Positive class.
    nbp_class u_class_pos (
        .clk      (clk),
        .cat      (category_value),
        .bin      (binary_value),
        .value    (numeric_value),
        .cat_lh   (cat_pos_reg),
        .bin_lh   (bin_lh_reg[2*PROB_BITS +: 2*PROB_BITS]),
        .prior    (priors_reg[PROB_BITS +: PROB_BITS]),
        .mean     (means_reg[VAL_W +: VAL_W]),
        .variance (vars_reg[VAL_W +: VAL_W]),
        .num      (num_pos)
    );

    // The products stay far below the range that would need pre-scaling, so
    // they go straight into the posterior divide.
    nbp_post u_post (
        .clk      (clk),
        .num_neg  (num_neg),
        .num_pos  (num_pos),
        .prob_neg (prob_negative),
        .prob_pos (prob_positive),
        .pred_pos (predicted_positive),
        .none     (no_evidence)
    );

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && no_evidence |->
            prob_negative == '0 && prob_positive == '0 && !predicted_positive)
        else $error("no_evidence beat carries nonzero posteriors");

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, TOTAL_LAT + 1))
        else $error("result beat without a matching record");

    a_pred_matches: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> predicted_positive == prob_positive[PROB_BITS-1])
        else $error("prediction disagrees with positive posterior");

endmodule
